// ----- design/wsd_pkg.sv -----
package wsd_pkg;

  // width of the frame length counter
  localparam int LEN_BITS = 63;

  // value carried on a close result
  localparam logic [7:0] CLOSE_BYTE = 8'h88;

  // short header length code that selects a 16-bit extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;

  // byte counts of the extended length and mask key fields
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // header bit positions
  localparam int FIN_BIT  = 7;
  localparam int CTRL_BIT = 3;
  localparam int MASK_BIT = 7;

  // tuser bit positions of the result channel
  localparam int U_CLOSE = 0;
  localparam int U_ERROR = 1;
  localparam int U_FIN   = 2;

  // one item handed from the parser to the output stage
  typedef struct packed {
    logic       is_close;
    logic       error;
    logic       fin;
    logic       last;
    logic [7:0] data;
    logic [7:0] key;
  } wsd_entry_t;

  // parser status
  typedef struct packed {
    logic closed;
    logic push;
  } wsd_stat_t;

endpackage

// ----- design/websocket_frame_deframer_unmasker_top.sv -----
// WebSocket receive deframer: takes one link byte per item (in_tuser high means the
// link closed), parses the frame header, extended length and mask key, and returns each
// payload byte unmasked, with the frame FIN on tuser and tlast on the final payload
// byte. A control opcode or a closed link gives one close result (0x88, tlast set); an
// unmasked frame gives a close with the error flag. After a close every item is taken
// and dropped until reset. Header bytes and zero-length frames give no result. One item
// is accepted every cycle while results are being taken; the parser feeds a two-entry
// queue ahead of the output register, so each result passes through that queue and
// then the output register, and in_tready falls only when that queue is full.
module websocket_frame_deframer_unmasker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] is_close, [1] error, [2] message_fin
  output logic       out_tlast   // last_of_frame
);

  wsd_pkg::wsd_entry_t push_entry;
  wsd_pkg::wsd_entry_t head;
  wsd_pkg::wsd_stat_t  stat;
  logic                q_full;
  logic                q_not_empty;
  logic                pop;
  logic [1:0]          q_count;

  // parser
  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_cmd     (in_tuser),
    .in_byte    (in_tdata),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push_entry (push_entry),
    .stat       (stat)
  );

  // queue between parser and output stage
  wsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (stat.push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full),
    .count      (q_count)
  );

  // unmask and output register
  wsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // no item is queued once the connection is closed
  assert property (@(posedge clk) disable iff (!rst_n) stat.closed |-> !stat.push)
    else $error("item queued after close");

  // the queue is never written while full
  assert property (@(posedge clk) disable iff (!rst_n) stat.push |-> (q_count != 2'd2))
    else $error("queue overflow");

  // nothing is taken from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> (q_count != 2'd0))
    else $error("queue underflow");

  // an error result is always a close
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_tvalid && out_tuser[wsd_pkg::U_ERROR]) |->
                   (out_tuser[wsd_pkg::U_CLOSE] && out_tlast))
    else $error("error flag without close");

endmodule

// ----- design/wsd_front.sv -----
module wsd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                in_ready,
  output wsd_pkg::wsd_entry_t push_entry,
  output wsd_pkg::wsd_stat_t  stat
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_DATA,
    PH_DONE
  } phase_t;

  localparam int LB = wsd_pkg::LEN_BITS;

  phase_t        phase_r, phase_nxt;
  logic          fin_r, fin_nxt;
  logic [LB-1:0] len_r, len_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [31:0]   mask_r, mask_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          closed_r, closed_nxt;

  logic          accept;
  logic          push;
  wsd_pkg::wsd_entry_t ent;
  logic [7:0]    ext_byte;
  logic [6:0]    len7;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // parse one byte, work out the next state and the item to queue
  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    mask_nxt   = mask_r;
    idx_nxt    = idx_r;
    closed_nxt = closed_r;
    push       = 1'b0;
    ent        = '0;
    len7       = in_byte[6:0];
    ext_byte   = in_byte;
    if (accept && !closed_r) begin
      if (in_cmd) begin
        push         = 1'b1;
        ent.is_close = 1'b1;
      end else begin
        case (phase_r)
          PH_HDR0: begin
            if (in_byte[wsd_pkg::CTRL_BIT]) begin
              push         = 1'b1;
              ent.is_close = 1'b1;
            end else begin
              fin_nxt   = in_byte[wsd_pkg::FIN_BIT];
              phase_nxt = PH_HDR1;
            end
          end
          PH_HDR1: begin
            if (!in_byte[wsd_pkg::MASK_BIT]) begin
              push         = 1'b1;
              ent.is_close = 1'b1;
              ent.error    = 1'b1;
            end else if (len7 < wsd_pkg::LEN_EXT16) begin
              len_nxt   = LB'(len7);
              cnt_nxt   = wsd_pkg::KEY_BYTES;
              phase_nxt = PH_MASK;
            end else begin
              len_nxt   = '0;
              cnt_nxt   = (len7 == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                       : wsd_pkg::EXT64_BYTES;
              phase_nxt = PH_EXT;
            end
          end
          PH_EXT: begin
            // top bit of a 64-bit length is dropped
            if (cnt_r == wsd_pkg::EXT64_BYTES) begin
              ext_byte = {1'b0, in_byte[6:0]};
            end
            // saturate once the length would leave the counter
            if (|len_r[LB-1:LB-8]) begin
              len_nxt = {LB{1'b1}};
            end else begin
              len_nxt = {len_r[LB-9:0], ext_byte};
            end
            cnt_nxt = cnt_r - 4'd1;
            if (cnt_r == 4'd1) begin
              cnt_nxt   = wsd_pkg::KEY_BYTES;
              phase_nxt = PH_MASK;
            end
          end
          PH_MASK: begin
            mask_nxt = {mask_r[23:0], in_byte};
            cnt_nxt  = cnt_r - 4'd1;
            if (cnt_r == 4'd1) begin
              idx_nxt   = '0;
              phase_nxt = (len_r == '0) ? PH_HDR0 : PH_DATA;
            end
          end
          PH_DATA: begin
            push     = 1'b1;
            ent.data = in_byte;
            ent.fin  = fin_r;
            ent.last = (len_r == LB'(1));
            case (idx_r)
              2'd0:    ent.key = mask_r[31:24];
              2'd1:    ent.key = mask_r[23:16];
              2'd2:    ent.key = mask_r[15:8];
              default: ent.key = mask_r[7:0];
            endcase
            idx_nxt = idx_r + 2'd1;
            len_nxt = len_r - LB'(1);
            if (len_r == LB'(1)) begin
              phase_nxt = PH_HDR0;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      // a close ends the connection until reset
      if (ent.is_close) begin
        ent.fin    = 1'b1;
        ent.last   = 1'b1;
        phase_nxt  = PH_DONE;
        closed_nxt = 1'b1;
        fin_nxt    = 1'b1;
        len_nxt    = '0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      fin_r    <= 1'b0;
      len_r    <= '0;
      cnt_r    <= '0;
      mask_r   <= '0;
      idx_r    <= '0;
      closed_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      mask_r   <= mask_nxt;
      idx_r    <= idx_nxt;
      closed_r <= closed_nxt;
    end
  end

  assign push_entry  = ent;
  assign stat.push   = push;
  assign stat.closed = closed_r;

endmodule

// ----- design/wsd_queue.sv -----
module wsd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wsd_pkg::wsd_entry_t push_entry,
  input  logic                pop,
  output wsd_pkg::wsd_entry_t head,
  output logic                not_empty,
  output logic                full,
  output logic [1:0]          count
);

  wsd_pkg::wsd_entry_t mem_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign count     = count_r;

endmodule

// ----- design/wsd_back.sv -----
module wsd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wsd_pkg::wsd_entry_t head,
  input  logic                q_not_empty,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic [2:0]          out_tuser,
  output logic                out_tlast
);

  logic       valid_r;
  logic [7:0] data_r, data_nxt;
  logic [2:0] user_r, user_nxt;
  logic       last_r;

  // take the head item when the output register is free or draining
  assign pop = q_not_empty && (!valid_r || out_tready);

  // unmask a payload byte, or form the close result
  always_comb begin
    data_nxt = head.is_close ? wsd_pkg::CLOSE_BYTE : (head.data ^ head.key);
    user_nxt = '0;
    user_nxt[wsd_pkg::U_CLOSE] = head.is_close;
    user_nxt[wsd_pkg::U_ERROR] = head.error;
    user_nxt[wsd_pkg::U_FIN]   = head.fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
      last_r <= head.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ----- sim/tb_websocket_frame_deframer_unmasker_top.sv -----
module tb_websocket_frame_deframer_unmasker_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1780;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  localparam logic [63:0] LEN_MAX   = (64'd1 << wsd_pkg::LEN_BITS) - 64'd1;
  localparam logic [6:0]  LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA, PH_DONE
  } parse_phase_t;

  typedef enum logic [1:0] {
    CLOSE_LINK, CLOSE_CTRL, CLOSE_UNMASKED
  } close_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_close;
    logic       error;
    logic       fin;
    logic       last;
  } ws_result_t;

  // dut signals
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] rx_byte
  logic       in_tuser   = 1'b0;   // [0] cmd
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic [2:0] out_tuser;           // [0] is_close, [1] error, [2] message_fin
  logic       out_tlast;

  // predictor state of the frame parser
  parse_phase_t ph;
  logic         fin_q;
  logic [63:0]  len_left;
  logic [3:0]   ext_left;
  logic [31:0]  key_word;
  logic [1:0]   key_idx;
  logic         closed_q;

  // bookkeeping
  ws_result_t  expected_results[$];
  int          fail_count     = 0;
  int          items_sent     = 0;
  int          results_seen   = 0;
  int          frames_sent    = 0;
  int          cycle_count    = 0;
  int          rx_hold_cycles = 0;
  bit          idle_on        = 1'b1;
  close_kind_t close_kind     = CLOSE_LINK;

  websocket_frame_deframer_unmasker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // close result, parser stays shut until reset
  function automatic void close_result(input logic err, output ws_result_t r);
    ph       = PH_DONE;
    closed_q = 1'b1;
    fin_q    = 1'b1;
    len_left = '0;
    r.data     = wsd_pkg::CLOSE_BYTE;
    r.is_close = 1'b1;
    r.error    = err;
    r.fin      = 1'b1;
    r.last     = 1'b1;
  endfunction

  // advance the parser by one received item, giving at most one result
  function automatic void deframe_step(input logic cmd, input logic [7:0] b,
                                       output logic got, output ws_result_t r);
    logic [7:0] key;
    logic [7:0] lb;
    got = 1'b0;
    r   = '0;
    if (closed_q) return;
    if (cmd) begin
      close_result(1'b0, r);
      got = 1'b1;
      return;
    end
    case (ph)
      PH_HDR0: begin
        if (b[wsd_pkg::CTRL_BIT]) begin
          close_result(1'b0, r);
          got = 1'b1;
        end else begin
          fin_q = b[wsd_pkg::FIN_BIT];
          ph    = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (!b[wsd_pkg::MASK_BIT]) begin
          close_result(1'b1, r);
          got = 1'b1;
        end else begin
          len_left = '0;
          if (b[6:0] < wsd_pkg::LEN_EXT16) begin
            len_left = {57'd0, b[6:0]};
            ext_left = wsd_pkg::KEY_BYTES;
            ph       = PH_KEY;
          end else begin
            ext_left = (b[6:0] == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                      : wsd_pkg::EXT64_BYTES;
            ph       = PH_EXT;
          end
        end
      end
      PH_EXT: begin
        lb = b;
        // top bit of a 64-bit length is dropped
        if (ext_left == wsd_pkg::EXT64_BYTES) lb[7] = 1'b0;
        if (len_left > (LEN_MAX >> 8)) begin
          len_left = LEN_MAX;
        end else begin
          len_left = (len_left << 8) | {56'd0, lb};
          if (len_left > LEN_MAX) len_left = LEN_MAX;
        end
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) begin
          ext_left = wsd_pkg::KEY_BYTES;
          ph       = PH_KEY;
        end
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) begin
          key_idx = 2'd0;
          ph      = (len_left == 64'd0) ? PH_HDR0 : PH_DATA;
        end
      end
      PH_DATA: begin
        key     = key_word[8 * (3 - key_idx) +: 8];
        key_idx = key_idx + 2'd1;
        if (len_left != 64'd0) len_left = len_left - 64'd1;
        r.data = b ^ key;
        r.fin  = fin_q;
        r.last = (len_left == 64'd0);
        got    = 1'b1;
        if (len_left == 64'd0) ph = PH_HDR0;
      end
      default: ;
    endcase
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item, predict on acceptance, then idle a while
  task automatic send_item(input logic cmd, input logic [7:0] b);
    logic       got;
    ws_result_t r;
    int         gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_step(cmd, b, got, r);
    if (got) expected_results.push_back(r);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // header, extended length and mask key of one masked data frame
  task automatic send_frame_header(input logic fin, input logic [63:0] len,
                                   input logic [6:0] len_code, input logic [31:0] key,
                                   input logic ext64_top);
    logic [7:0] hdr0;
    logic [7:0] lb;
    hdr0 = 8'($urandom_range(0, 255));
    hdr0[wsd_pkg::FIN_BIT]  = fin;
    hdr0[wsd_pkg::CTRL_BIT] = 1'b0;
    send_item(1'b0, hdr0);
    send_item(1'b0, {1'b1, len_code});
    if (len_code == wsd_pkg::LEN_EXT16) begin
      send_item(1'b0, len[15:8]);
      send_item(1'b0, len[7:0]);
    end else if (len_code == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) begin
        lb = len[8 * i +: 8];
        if (i == 7) lb[7] = ext64_top;
        send_item(1'b0, lb);
      end
    end
    for (int k = 0; k < 4; k++) send_item(1'b0, key[8 * (3 - k) +: 8]);
  endtask

  task automatic send_frame(input logic fin, input int len, input logic [6:0] len_code);
    send_frame_header(fin, 64'(len), len_code, $urandom, 1'($urandom_range(0, 1)));
    for (int k = 0; k < len; k++) send_item(1'b0, 8'($urandom_range(0, 255)));
    frames_sent++;
  endtask

  // zero-length frame with a 64-bit length, then a short non-final frame
  task automatic test_directed_frames();
    idle_on = 1'b0;
    send_frame_header(1'b1, 64'd0, LEN_EXT64, 32'h0000_0000, 1'b1);
    send_frame_header(1'b0, 64'd5, 7'd5, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'hA5);
    send_item(1'b0, 8'($urandom_range(0, 255)));
    frames_sent += 2;
    idle_on = 1'b1;
  endtask

  // well-formed masked frames of mixed length encodings
  task automatic test_random_frames();
    int         stop_at;
    int         r;
    int         len;
    logic [6:0] code;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      idle_on = ($urandom_range(0, 7) != 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        len  = $urandom_range(0, 40);
        code = 7'(len);
      end else if (r < 80) begin
        len  = $urandom_range(0, 200);
        code = wsd_pkg::LEN_EXT16;
      end else if (r < 92) begin
        len  = $urandom_range(0, 60);
        code = LEN_EXT64;
      end else begin
        len  = $urandom_range(100, 125);
        code = 7'(len);
      end
      send_frame(1'($urandom_range(0, 1)), len, code);
    end
    idle_on = 1'b1;
  endtask

  // receiver stops for a long stretch while a long frame streams in
  task automatic test_backpressure();
    idle_on        = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    send_frame(1'b1, 90, 7'd90);
    idle_on = 1'b1;
  endtask

  // one way of ending the connection, then items that must be dropped
  task automatic test_connection_close();
    logic [7:0] b;
    close_kind = close_kind_t'($urandom_range(0, 2));
    case (close_kind)
      CLOSE_LINK: begin
        // huge 64-bit length frame cut short by the link going down
        send_frame_header(1'($urandom_range(0, 1)), {$urandom, $urandom}, LEN_EXT64,
                          $urandom, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 30)) send_item(1'b0, 8'($urandom_range(0, 255)));
        send_item(1'b1, 8'($urandom_range(0, 255)));
      end
      CLOSE_CTRL: begin
        b = 8'($urandom_range(0, 255));
        b[wsd_pkg::CTRL_BIT] = 1'b1;
        send_item(1'b0, b);
      end
      default: begin
        b = 8'($urandom_range(0, 255));
        b[wsd_pkg::CTRL_BIT] = 1'b0;
        send_item(1'b0, b);
        b = 8'($urandom_range(0, 255));
        b[wsd_pkg::MASK_BIT] = 1'b0;
        send_item(1'b0, b);
      end
    endcase
    send_item(1'b1, 8'($urandom_range(0, 255)));
    repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // receiver: random stalls plus the long hold-off on request
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    ws_result_t seen;
    ws_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.data     = out_tdata;
      seen.is_close = out_tuser[wsd_pkg::U_CLOSE];
      seen.error    = out_tuser[wsd_pkg::U_ERROR];
      seen.fin      = out_tuser[wsd_pkg::U_FIN];
      seen.last     = out_tlast;
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: data %02h close %0b err %0b fin %0b last %0b",
                   seen.data, seen.is_close, seen.error, seen.fin, seen.last);
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch on result %0d", results_seen);
            $display("  expected data %02h close %0b err %0b fin %0b last %0b",
                     want.data, want.is_close, want.error, want.fin, want.last);
            $display("  actual   data %02h close %0b err %0b fin %0b last %0b",
                     seen.data, seen.is_close, seen.error, seen.fin, seen.last);
          end
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    ph       = PH_HDR0;
    fin_q    = 1'b0;
    len_left = '0;
    ext_left = '0;
    key_word = '0;
    key_idx  = '0;
    closed_q = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_frames();
    test_backpressure();
    test_connection_close();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d frames over %0d items, %0d results checked, %0d failures",
             frames_sent, items_sent, results_seen, fail_count);
    $display("long receiver hold-off done, connection ended by %s", close_kind.name());
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer_unmasker_top.sv
sim/tb_websocket_frame_deframer_unmasker_top.sv
